// ===== rtl/c2d_pkg.sv =====
// ----------------------------------------------------------------------------
// c2d_pkg: shared types and codes for the multichannel convolution unit
// Function codes, register indexes and the job record passed front to back.
// ----------------------------------------------------------------------------
package c2d_pkg;

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_WEIGHT = 2'd1,
		FUNC_BIAS   = 2'd2,
		FUNC_REQ    = 2'd3
	} func_t;

	localparam logic [2:0] REG_IN_HEIGHT = 3'd0;
	localparam logic [2:0] REG_IN_WIDTH  = 3'd1;
	localparam logic [2:0] REG_IN_CH     = 3'd2;
	localparam logic [2:0] REG_OUT_CH    = 3'd3;
	localparam logic [2:0] REG_STRIDE_R  = 3'd4;
	localparam logic [2:0] REG_STRIDE_C  = 3'd5;
	localparam logic [2:0] REG_PAD_R     = 3'd6;
	localparam logic [2:0] REG_PAD_C     = 3'd7;

	localparam int ACC_W = 40;
	localparam logic signed [47:0] SAT_MAX = 48'sd549755813887;
	localparam logic signed [47:0] SAT_MIN = -48'sd549755813888;

	// one request handed from front to back
	typedef struct packed {
		logic [3:0] filt;
		logic [5:0] row;
		logic [5:0] col;
		logic       ok;
	} job_t;

endpackage

// ===== rtl/c2d_ram.sv =====
// ----------------------------------------------------------------------------
// c2d_ram: generic single-port-write, single-port-read RAM
// Registered read data, no reset on the array.
// ----------------------------------------------------------------------------
module c2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/c2d_front.sv =====
// ----------------------------------------------------------------------------
// c2d_front: input decode and range check
// Routes store writes and pushes output requests into a small job queue.
// ----------------------------------------------------------------------------
module c2d_front #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int MAX_IN_CH = 16,
	parameter int MAX_OUT_CH = 16,
	parameter int KERNEL_ROWS = 3,
	parameter int KERNEL_COLS = 3,
	localparam int IMG_D = MAX_IN_CH * MAX_ROWS * MAX_COLS,
	localparam int WGT_D = MAX_OUT_CH * MAX_IN_CH * KERNEL_ROWS * KERNEL_COLS,
	localparam int IMG_AW = $clog2(IMG_D),
	localparam int WGT_AW = $clog2(WGT_D)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic [3:0]        filt,
	input  logic [3:0]        chan,
	input  logic [5:0]        row,
	input  logic [5:0]        col,
	input  logic [15:0]       data,
	input  logic [31:0]       bias,
	input  logic [10:0]       oh,
	input  logic [10:0]       ow,
	input  logic [8:0]        och,
	input  logic              back_busy,
	output logic              img_we,
	output logic [IMG_AW-1:0] img_waddr,
	output logic              wgt_we,
	output logic [WGT_AW-1:0] wgt_waddr,
	output logic [15:0]       wdata,
	output logic              bias_we,
	output logic [3:0]        bias_waddr,
	output logic [31:0]       bias_wdata,
	output logic              job_valid,
	input  logic              job_ready,
	output c2d_pkg::job_t     job
);
	localparam int QD = 2;
	c2d_pkg::job_t q_q [QD];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic       acc, push, pop;

	// hold store writes until every earlier request has read the stores
	assign in_ready  = cnt_q != 2'(QD)
		&& (func == c2d_pkg::FUNC_REQ || (cnt_q == 2'd0 && !back_busy));
	assign acc       = in_valid && in_ready;
	assign push      = acc && func == c2d_pkg::FUNC_REQ;
	assign pop       = job_valid && job_ready;
	assign job_valid = cnt_q != 2'd0;
	assign job       = q_q[rd_q];

	assign wdata      = data;
	assign bias_wdata = bias;
	assign bias_waddr = filt;
	assign img_we  = acc && func == c2d_pkg::FUNC_SAMPLE && 32'(chan) < MAX_IN_CH
		&& 32'(row) < MAX_ROWS && 32'(col) < MAX_COLS;
	assign wgt_we  = acc && func == c2d_pkg::FUNC_WEIGHT && 32'(filt) < MAX_OUT_CH
		&& 32'(chan) < MAX_IN_CH && 32'(row) < KERNEL_ROWS && 32'(col) < KERNEL_COLS;
	assign bias_we = acc && func == c2d_pkg::FUNC_BIAS && 32'(filt) < MAX_OUT_CH;
	assign img_waddr = IMG_AW'((32'(chan) * MAX_ROWS + 32'(row)) * MAX_COLS + 32'(col));
	assign wgt_waddr = WGT_AW'(((32'(filt) * MAX_IN_CH + 32'(chan)) * KERNEL_ROWS
		+ 32'(row)) * KERNEL_COLS + 32'(col));

	c2d_pkg::job_t nj;
	always_comb begin
		nj.filt = filt;
		nj.row  = row;
		nj.col  = col;
		nj.ok   = 9'(filt) < och && 11'(row) < oh && 11'(col) < ow;
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== rtl/c2d_back.sv =====
// ----------------------------------------------------------------------------
// c2d_back: multiply-accumulate sequencer
// Walks channels and taps one per cycle, then adds bias and saturates; out-of-range jobs skip to a zero result.
// ----------------------------------------------------------------------------
module c2d_back #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int MAX_IN_CH = 16,
	parameter int MAX_OUT_CH = 16,
	parameter int KERNEL_ROWS = 3,
	parameter int KERNEL_COLS = 3,
	localparam int IMG_D = MAX_IN_CH * MAX_ROWS * MAX_COLS,
	localparam int WGT_D = MAX_OUT_CH * MAX_IN_CH * KERNEL_ROWS * KERNEL_COLS,
	localparam int IMG_AW = $clog2(IMG_D),
	localparam int WGT_AW = $clog2(WGT_D)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  c2d_pkg::job_t     job,
	output logic              busy,
	input  logic [10:0]       ih,
	input  logic [10:0]       iw,
	input  logic [8:0]        ich,
	input  logic [3:0]        sr,
	input  logic [3:0]        sc,
	input  logic              pr,
	input  logic              pc,
	output logic [IMG_AW-1:0] img_raddr,
	input  logic [15:0]       img_rdata,
	output logic [WGT_AW-1:0] wgt_raddr,
	input  logic [15:0]       wgt_rdata,
	input  logic [31:0]       bias_rdata,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [39:0]       out_value,
	output logic [3:0]        out_filter,
	output logic [5:0]        out_row,
	output logic [5:0]        out_col,
	output logic              out_ok
);
	typedef enum logic [2:0] {IDLE, RUN, DRAIN1, DRAIN2, BIAS, HOLD} st_t;
	st_t st_q;
	c2d_pkg::job_t j_q;
	logic [8:0]  ch_q;
	logic [3:0]  kr_q, kc_q;
	logic        v_s1, v_s2;
	logic signed [31:0] p_s2;
	logic signed [47:0] acc_q;
	logic signed [12:0] y, x;
	logic inb, last;
	logic signed [47:0] tot;

	localparam int PH = KERNEL_ROWS / 2;
	localparam int PW = KERNEL_COLS / 2;

	always_comb begin
		y = 13'(j_q.row) * $signed({9'd0, sr}) + 13'(kr_q) - (pr ? 13'(PH) : 13'd0);
		x = 13'(j_q.col) * $signed({9'd0, sc}) + 13'(kc_q) - (pc ? 13'(PW) : 13'd0);
		inb = y >= 0 && y < $signed({2'b0, ih}) && x >= 0 && x < $signed({2'b0, iw});
		img_raddr = IMG_AW'((32'(ch_q) * MAX_ROWS + 32'(y[11:0])) * MAX_COLS
			+ 32'(x[11:0]));
		wgt_raddr = WGT_AW'(((32'(j_q.filt) * MAX_IN_CH + 32'(ch_q)) * KERNEL_ROWS
			+ 32'(KERNEL_ROWS - 1) - 32'(kr_q)) * KERNEL_COLS
			+ 32'(KERNEL_COLS - 1) - 32'(kc_q));
		last = 32'(kc_q) == KERNEL_COLS - 1 && 32'(kr_q) == KERNEL_ROWS - 1
			&& ch_q == ich - 9'd1;
		tot = acc_q + 48'($signed(bias_rdata));
	end

	assign job_ready = st_q == IDLE;
	// stores are read from the first tap up to the bias add
	assign busy = st_q != IDLE && st_q != HOLD;

	always_ff @(posedge clk) begin
		p_s2 <= $signed(img_rdata) * $signed(wgt_rdata);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= st_q == RUN && inb;
			v_s2 <= v_s1;
			if (v_s2) acc_q <= acc_q + 48'(p_s2);
			unique case (st_q)
				IDLE: if (job_valid) begin
					j_q <= job;
					ch_q <= '0; kr_q <= '0; kc_q <= '0;
					acc_q <= '0;
					st_q <= job.ok ? RUN : BIAS;
				end
				RUN: begin
					if (last) st_q <= DRAIN1;
					if (32'(kc_q) == KERNEL_COLS - 1) begin
						kc_q <= '0;
						if (32'(kr_q) == KERNEL_ROWS - 1) begin
							kr_q <= '0;
							ch_q <= ch_q + 9'd1;
						end else kr_q <= kr_q + 4'd1;
					end else kc_q <= kc_q + 4'd1;
				end
				DRAIN1: st_q <= DRAIN2;
				DRAIN2: st_q <= BIAS;
				BIAS: begin
					out_valid  <= 1'b1;
					out_filter <= j_q.filt;
					out_row    <= j_q.row;
					out_col    <= j_q.col;
					out_ok     <= j_q.ok;
					if (!j_q.ok) out_value <= '0;
					else if (tot > c2d_pkg::SAT_MAX) out_value <= c2d_pkg::SAT_MAX[39:0];
					else if (tot < c2d_pkg::SAT_MIN) out_value <= c2d_pkg::SAT_MIN[39:0];
					else out_value <= tot[39:0];
					st_q <= HOLD;
				end
				HOLD: if (out_ready) begin
					out_valid <= 1'b0;
					st_q <= IDLE;
				end
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/conv2d_forward_multichannel_unit.sv =====
// ----------------------------------------------------------------------------
// conv2d_forward_multichannel_unit: multichannel 2D convolution, one image
// Store writes and output requests in; one saturated Q.20 sum per request out.
// ----------------------------------------------------------------------------
// channel  dir  payload
// s_axis   in   tdata: func, filter, channel, row, col, data, bias
// m_axis   out  tdata: value, filter, row, col ; tuser: in_range
// cfg      in   index, data (register write)
//
// Requests are served one at a time by the single multiply-accumulate unit,
// with one RAM read port per store. A store write waits until every
// earlier request has finished reading the stores. Stores are not cleared
// by reset. A two-deep request queue takes requests while the accumulator
// runs or the output stalls.
module conv2d_forward_multichannel_unit #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int MAX_IN_CH = 16,
	parameter int MAX_OUT_CH = 16,
	parameter int KERNEL_ROWS = 3,
	parameter int KERNEL_COLS = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// func[1:0] filter[5:2] channel[9:6] row[15:10] col[21:16] data[37:22] bias[69:38]
	input  logic [71:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// value[39:0] filter[43:40] row[49:44] col[55:50]
	output logic [55:0]  m_axis_tdata,
	// in_range[0]
	output logic         m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [6:0]   cfg_data
);
	localparam int IMG_D = MAX_IN_CH * MAX_ROWS * MAX_COLS;
	localparam int WGT_D = MAX_OUT_CH * MAX_IN_CH * KERNEL_ROWS * KERNEL_COLS;
	localparam int IMG_AW = $clog2(IMG_D);
	localparam int WGT_AW = $clog2(WGT_D);

	logic [6:0] ih_q, iw_q;
	logic [4:0] ich_q, och_q;
	logic [3:0] sr_q, sc_q;
	logic       pr_q, pc_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ih_q <= 7'd64; iw_q <= 7'd64; ich_q <= 5'd1; och_q <= 5'd1;
			sr_q <= 4'd1; sc_q <= 4'd1; pr_q <= 1'b0; pc_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				c2d_pkg::REG_IN_HEIGHT: ih_q  <= cfg_data;
				c2d_pkg::REG_IN_WIDTH:  iw_q  <= cfg_data;
				c2d_pkg::REG_IN_CH:     ich_q <= cfg_data[4:0];
				c2d_pkg::REG_OUT_CH:    och_q <= cfg_data[4:0];
				c2d_pkg::REG_STRIDE_R:  sr_q  <= cfg_data[3:0];
				c2d_pkg::REG_STRIDE_C:  sc_q  <= cfg_data[3:0];
				c2d_pkg::REG_PAD_R:     pr_q  <= cfg_data[0];
				default:                pc_q  <= cfg_data[0];
			endcase
		end
	end

	// clamp register values and derive output sizes
	logic [10:0] ih, iw, rh, rw, oh, ow;
	logic [8:0]  ich, och;
	logic [3:0]  sr, sc;
	always_comb begin
		ih  = (ih_q == 7'd0) ? 11'd1 : (32'(ih_q) > MAX_ROWS ? 11'(MAX_ROWS) : 11'(ih_q));
		iw  = (iw_q == 7'd0) ? 11'd1 : (32'(iw_q) > MAX_COLS ? 11'(MAX_COLS) : 11'(iw_q));
		ich = (ich_q == 5'd0) ? 9'd1 : (32'(ich_q) > MAX_IN_CH ? 9'(MAX_IN_CH) : 9'(ich_q));
		och = (och_q == 5'd0) ? 9'd1 : (32'(och_q) > MAX_OUT_CH ? 9'(MAX_OUT_CH) : 9'(och_q));
		sr  = (sr_q == 4'd0) ? 4'd1 : sr_q;
		sc  = (sc_q == 4'd0) ? 4'd1 : sc_q;
		rh  = pr_q ? ih : (32'(ih) > KERNEL_ROWS - 1 ? ih - 11'(KERNEL_ROWS - 1) : 11'd0);
		rw  = pc_q ? iw : (32'(iw) > KERNEL_COLS - 1 ? iw - 11'(KERNEL_COLS - 1) : 11'd0);
	end

	// ceil divide by stride 1..15: shift for powers of two, else reciprocal multiply
	function automatic logic [10:0] cdiv(input logic [10:0] n, input logic [3:0] s);
		logic [10:0] t;
		t = n + 11'(s) - 11'd1;
		case (s)
			4'd1: cdiv = n;
			4'd2: cdiv = t >> 1;
			4'd3: cdiv = 11'((22'(t) * 22'd683) >> 11);
			4'd4: cdiv = t >> 2;
			4'd5: cdiv = 11'((22'(t) * 22'd1639) >> 13);
			4'd6: cdiv = 11'((22'(t) * 22'd683) >> 12);
			4'd7: cdiv = 11'((24'(t) * 24'd2341) >> 14);
			4'd8: cdiv = t >> 3;
			4'd9: cdiv = 11'((24'(t) * 24'd911) >> 13);
			4'd10: cdiv = 11'((24'(t) * 24'd820) >> 13);
			4'd11: cdiv = 11'((24'(t) * 24'd745) >> 13);
			4'd12: cdiv = 11'((24'(t) * 24'd683) >> 13);
			4'd13: cdiv = 11'((24'(t) * 24'd631) >> 13);
			4'd14: cdiv = 11'((24'(t) * 24'd586) >> 13);
			4'd15: cdiv = 11'((24'(t) * 24'd547) >> 13);
			default: cdiv = n;
		endcase
	endfunction

	assign oh = cdiv(rh, sr);
	assign ow = cdiv(rw, sc);

	logic              img_we, wgt_we, bias_we, job_valid, job_ready, back_busy;
	logic [IMG_AW-1:0] img_waddr, img_raddr;
	logic [WGT_AW-1:0] wgt_waddr, wgt_raddr;
	logic [15:0]       wdata, img_rdata, wgt_rdata;
	logic [3:0]        bias_waddr;
	logic [31:0]       bias_wdata, bias_rdata;
	logic [31:0]       bias_q [16];
	logic [3:0]        job_sel_q;
	c2d_pkg::job_t     job;
	logic [39:0]       out_value;
	logic [3:0]        out_filter;
	logic [5:0]        out_row, out_col;

	c2d_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_IN_CH(MAX_IN_CH),
		.MAX_OUT_CH(MAX_OUT_CH), .KERNEL_ROWS(KERNEL_ROWS), .KERNEL_COLS(KERNEL_COLS))
	u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.func(s_axis_tdata[1:0]), .filt(s_axis_tdata[5:2]), .chan(s_axis_tdata[9:6]),
		.row(s_axis_tdata[15:10]), .col(s_axis_tdata[21:16]),
		.data(s_axis_tdata[37:22]), .bias(s_axis_tdata[69:38]),
		.oh, .ow, .och, .back_busy, .img_we, .img_waddr, .wgt_we, .wgt_waddr, .wdata,
		.bias_we, .bias_waddr, .bias_wdata, .job_valid, .job_ready, .job
	);

	c2d_ram #(.WIDTH(16), .DEPTH(IMG_D)) u_img (
		.clk, .we(img_we), .waddr(img_waddr), .wdata, .raddr(img_raddr), .rdata(img_rdata)
	);
	c2d_ram #(.WIDTH(16), .DEPTH(WGT_D)) u_wgt (
		.clk, .we(wgt_we), .waddr(wgt_waddr), .wdata, .raddr(wgt_raddr), .rdata(wgt_rdata)
	);

	// bias registers, one per filter, read at the request's filter
	always_ff @(posedge clk) begin
		if (bias_we) bias_q[bias_waddr] <= bias_wdata;
	end
	always_ff @(posedge clk) begin
		if (job_valid && job_ready) job_sel_q <= job.filt;
	end
	assign bias_rdata = bias_q[job_sel_q];

	c2d_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_IN_CH(MAX_IN_CH),
		.MAX_OUT_CH(MAX_OUT_CH), .KERNEL_ROWS(KERNEL_ROWS), .KERNEL_COLS(KERNEL_COLS))
	u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job, .busy(back_busy),
		.ih, .iw, .ich, .sr, .sc, .pr(pr_q), .pc(pc_q),
		.img_raddr, .img_rdata, .wgt_raddr, .wgt_rdata, .bias_rdata,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_value, .out_filter, .out_row, .out_col, .out_ok(m_axis_tuser)
	);

	assign m_axis_tdata = {out_col, out_row, out_filter, out_value};
endmodule

// ===== rtl/c2d_checker.sv =====
// ----------------------------------------------------------------------------
// c2d_checker: port-level checks on the convolution unit
// Output stability under stall, range-flag consistency and result spacing.
// ----------------------------------------------------------------------------
module c2d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic        m_axis_tuser
);
	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
	// out-of-range results carry a zero value
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[39:0] == 40'd0)
		else $error("out of range result not zero");
	// results are separated: valid drops after each accepted result
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
		else $error("back to back results");
endmodule

bind conv2d_forward_multichannel_unit c2d_checker u_chk (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
